@@ hw/rtl/mtf_pkg.sv @@
// Package for the move-to-front LRU cache: sizes, cell data and cell control types.
// No dependencies; used by mtf_cell and move_to_front_lru_cache_top.
`default_nettype none

package mtf_pkg;

    localparam int CACHE_DEPTH = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    // One slot as it moves along the chain.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cell_data_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic cmp_en;    // capture match against the broadcast key
        logic shift_en;  // load from the neighbor in front
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtf_cell.sv @@
// One slot of the recency chain: valid/key/value registers plus a match flag.
// Depends on mtf_pkg.
`default_nettype none

module mtf_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mtf_pkg::cell_ctl_t            ctl,
    input  wire logic [mtf_pkg::KEY_W-1:0]     cmp_key,
    input  wire mtf_pkg::cell_data_t           prev_data,
    output mtf_pkg::cell_data_t                data,
    output logic                               match
);

    logic                      valid_reg;
    logic [mtf_pkg::KEY_W-1:0] key_reg;
    logic [mtf_pkg::VAL_W-1:0] value_reg;
    logic                      match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.shift_en)
            begin
                valid_reg <= prev_data.valid;
            end
            if (ctl.cmp_en)
            begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            key_reg   <= prev_data.key;
            value_reg <= prev_data.value;
        end
    end

    assign data.valid = valid_reg;
    assign data.key   = key_reg;
    assign data.value = value_reg;
    assign match      = match_reg;

endmodule

`default_nettype wire

@@ hw/rtl/move_to_front_lru_cache_top.sv @@
// Top level of the move-to-front LRU cache: sequencer, front-slot select and a chain of cells.
// Depends on mtf_pkg and mtf_cell.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+-------------------------------
//  command   | start, mode, key, entry_value, busy       | edge with start=1, busy=0
//  result    | done, hit, found_value, released,         | edge ending the cycle done=1
//            | released_value                            |
//
// At the accepting edge every cell compares its key with the key port and registers a
// match flag. In the next cycle the first match is picked, the chain shifts by one
// toward the back up to that slot (or fully on an insert miss), and the result is
// registered; done is high in the following cycle, when busy is low again, so a new
// command can be taken while the result is shown.
// Reset clears all valid flags; keys and values are only looked at for valid slots.
// Results cannot be stalled: each is shown for one cycle only.
`default_nettype none

module move_to_front_lru_cache_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          mode,
    input  wire logic [mtf_pkg::KEY_W-1:0]     key,
    input  wire logic [mtf_pkg::VAL_W-1:0]     entry_value,
    output logic                               done,
    output logic                               hit,
    output logic [mtf_pkg::VAL_W-1:0]          found_value,
    output logic                               released,
    output logic [mtf_pkg::VAL_W-1:0]          released_value
);

    localparam int D = mtf_pkg::CACHE_DEPTH;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t                    state_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      hit_reg;
    logic [mtf_pkg::VAL_W-1:0] found_reg;
    logic                      released_reg;
    logic [mtf_pkg::VAL_W-1:0] released_value_reg;

    // command held for the update cycle
    logic                      mode_reg;
    logic [mtf_pkg::KEY_W-1:0] key_reg;
    logic [mtf_pkg::VAL_W-1:0] value_reg;

    logic                      accept;
    logic                      upd;

    mtf_pkg::cell_data_t       cell_data [D];
    mtf_pkg::cell_ctl_t        cell_ctl  [D];
    logic [D-1:0]              match;
    logic [D-1:0]              below;    // some match at a lower index
    logic [D-1:0]              sel;      // first match, one-hot
    logic                      any_hit;
    logic [mtf_pkg::VAL_W-1:0] sel_value;
    mtf_pkg::cell_data_t       front_data;
    logic                      rel_next;
    logic [mtf_pkg::VAL_W-1:0] rel_value_next;

    function automatic logic [D-1:0] low_mask(input int n);
        logic [D-1:0] m;
        for (int j = 0; j < D; j++)
        begin
            m[j] = (j < n);
        end
        return m;
    endfunction

    assign accept = start && !busy_reg;
    assign upd    = (state_reg == ST_UPDATE);

    // first-match select, lowest index wins
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            below[i] = |(match & low_mask(i));
            sel[i]   = match[i] && !below[i];
        end
    end

    assign any_hit = |match;

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < D; i++)
        begin
            sel_value = sel_value | (sel[i] ? cell_data[i].value : '0);
        end
    end

    // new front slot: the hit slot moved up, or the inserted entry; key equals key_reg
    assign front_data.valid = 1'b1;
    assign front_data.key   = key_reg;
    assign front_data.value = mode_reg ? value_reg : sel_value;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            cell_ctl[i].cmp_en   = accept;
            cell_ctl[i].shift_en = upd && (any_hit ? !below[i] : mode_reg);
        end
    end

    always_comb
    begin
        rel_next       = 1'b0;
        rel_value_next = '0;
        if (mode_reg)
        begin
            if (any_hit)
            begin
                rel_next       = 1'b1;
                rel_value_next = sel_value;
            end
            else if (cell_data[D-1].valid)
            begin
                rel_next       = 1'b1;
                rel_value_next = cell_data[D-1].value;
            end
        end
    end

    for (genvar g = 0; g < D; g++)
    begin : g_cell
        mtf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[g]),
            .cmp_key   (key),
            .prev_data ((g == 0) ? front_data : cell_data[(g == 0) ? 0 : g - 1]),
            .data      (cell_data[g]),
            .match     (match[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            busy_reg           <= 1'b0;
            done_reg           <= 1'b0;
            hit_reg            <= 1'b0;
            found_reg          <= '0;
            released_reg       <= 1'b0;
            released_value_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPDATE;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg          <= ST_IDLE;
                    busy_reg           <= 1'b0;
                    done_reg           <= 1'b1;
                    hit_reg            <= any_hit;
                    found_reg          <= sel_value;
                    released_reg       <= rel_next;
                    released_value_reg <= rel_value_next;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= entry_value;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign found_value    = found_reg;
    assign released       = released_reg;
    assign released_value = released_value_reg;

    // keys stay unique, so at most one slot matches
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> $onehot0(match))
        else $error("more than one slot matched");

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == upd)
        else $error("busy out of step with sequencer");

    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg ##1 (done_reg && !busy_reg))
        else $error("command did not complete in two cycles");

    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((hit_reg || found_reg == '0) &&
                      (released_reg || released_value_reg == '0)))
        else $error("value shown without its flag");

    a_lookup_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !mode_reg) |=> !released_reg)
        else $error("lookup released a value");

endmodule

`default_nettype wire
